FILE: hw/rtl/u2u8_pkg.sv
// shared types, constants and byte-encoding helpers for the utf-16/32 to utf-8 transcoder
package u2u8_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX_1B      = 21'h00007F;
    localparam logic [CP_W-1:0] CP_MAX_2B      = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_MAX_3B      = 21'h00FFFF;

    // sequence length codes: last byte index of the sequence
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    // lead byte prefixes
    localparam logic [2:0] LEAD_2 = 3'b110;
    localparam logic [3:0] LEAD_3 = 4'b1110;
    localparam logic [4:0] LEAD_4 = 5'b11110;
    localparam logic [1:0] CONT   = 2'b10;

    // one unit of work for the byte engine
    typedef struct packed {
        logic            pre_rep;   // emit the replacement character first
        logic            main;      // then encode cp
        logic [CP_W-1:0] cp;
    } t_entry;

    function automatic logic [1:0] len_code(input logic [CP_W-1:0] cp);
        logic [1:0] len;
        if (cp <= CP_MAX_1B) begin
            len = LEN_1;
        end else if (cp <= CP_MAX_2B) begin
            len = LEN_2;
        end else if (cp <= CP_MAX_3B) begin
            len = LEN_3;
        end else begin
            len = LEN_4;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0]      len,
                                             input logic [1:0]      idx);
        logic [7:0] b;
        logic [1:0] from_end;
        from_end = len - idx;
        if (idx == 2'd0) begin
            unique case (len)
                LEN_1:   b = {1'b0, cp[6:0]};
                LEN_2:   b = {LEAD_2, cp[10:6]};
                LEN_3:   b = {LEAD_3, cp[15:12]};
                LEN_4:   b = {LEAD_4, cp[20:18]};
                default: b = 8'h00;
            endcase
        end else begin
            unique case (from_end)
                2'd0:    b = {CONT, cp[5:0]};
                2'd1:    b = {CONT, cp[11:6]};
                2'd2:    b = {CONT, cp[17:12]};
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/u2u8_front.sv
// front end: accepts wide units, pairs surrogates and queues work for the byte engine
module u2u8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             i_in_valid,
    input  logic [20:0]      i_code_unit,
    input  logic             i_end_of_string,
    input  logic             i_q_full,
    output logic             o_in_ready,
    output logic             o_push,
    output u2u8_pkg::t_entry o_entry
);
    import u2u8_pkg::*;

    logic       r_mode32, n_mode32;
    logic       r_pend, n_pend;
    logic [9:0] r_held, n_held;

    logic        accept;
    logic [15:0] u16;
    logic        is_high, is_low;
    t_entry      ent;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign u16        = i_code_unit[15:0];
    assign is_high    = (u16 >= HIGH_FIRST) && (u16 <= HIGH_LAST);
    assign is_low     = (u16 >= LOW_FIRST) && (u16 <= LOW_LAST);

    always_comb begin
        ent     = '0;
        n_pend  = r_pend;
        n_held  = r_held;
        n_mode32 = r_mode32;
        if (r_mode32) begin
            ent.main = 1'b1;
            ent.cp   = i_code_unit;
            if (accept) begin
                n_pend = 1'b0;
                n_held = '0;
            end
        end else if (r_pend && is_low) begin
            ent.main = 1'b1;
            ent.cp   = CP_SUPP_BASE + {1'b0, r_held, u16[9:0]};
            if (accept) begin
                n_pend = 1'b0;
                n_held = '0;
            end
        end else begin
            ent.pre_rep = r_pend;
            if (accept) begin
                n_pend = 1'b0;
                n_held = '0;
            end
            if (is_high) begin
                if (i_end_of_string) begin
                    ent.main = 1'b1;
                    ent.cp   = {5'd0, u16};
                end else if (accept) begin
                    n_pend = 1'b1;
                    n_held = u16[9:0];
                end
            end else if (is_low) begin
                ent.main = 1'b1;
                ent.cp   = CP_REPLACEMENT;
            end else begin
                ent.main = 1'b1;
                ent.cp   = {5'd0, u16};
            end
        end
        // register write resets the surrogate tracker
        if (i_cfg_we) begin
            n_mode32 = i_cfg_wdata;
            n_pend   = 1'b0;
            n_held   = '0;
        end
    end

    assign o_push  = accept && (ent.pre_rep || ent.main);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode32 <= 1'b0;
            r_pend   <= 1'b0;
            r_held   <= '0;
        end else begin
            r_mode32 <= n_mode32;
            r_pend   <= n_pend;
            r_held   <= n_held;
        end
    end

endmodule

FILE: hw/rtl/u2u8_queue.sv
// small register queue between the front end and the byte engine
module u2u8_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u2u8_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output u2u8_pkg::t_entry o_entry
);
    import u2u8_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + AW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: hw/rtl/u2u8_back.sv
// byte engine: walks each queued entry and emits one utf-8 byte per cycle while the output side accepts
module u2u8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  u2u8_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_byte,
    output logic             o_last
);
    import u2u8_pkg::*;

    logic            r_busy;
    logic            r_rep;
    logic            r_main;
    logic [CP_W-1:0] r_cp;
    logic [1:0]      r_idx;
    logic            r_ov;
    logic [7:0]      r_obyte;
    logic            r_olast;

    logic [CP_W-1:0] cur_cp;
    logic [1:0]      cur_len;
    logic            at_end;
    logic            entry_last;
    logic            adv;

    assign cur_cp     = r_rep ? CP_REPLACEMENT : r_cp;
    assign cur_len    = len_code(cur_cp);
    assign at_end     = (r_idx == cur_len);
    assign entry_last = at_end && (!r_rep || !r_main);
    assign adv        = r_busy && (!r_ov || i_ready);
    assign o_pop      = i_q_valid && (!r_busy || (adv && entry_last));

    assign o_valid = r_ov;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_obyte <= utf8_byte(cur_cp, cur_len, r_idx);
            r_olast <= entry_last;
        end
        if (o_pop) begin
            r_rep  <= i_entry.pre_rep;
            r_main <= i_entry.main;
            r_cp   <= i_entry.cp;
        end else if (adv && at_end && !entry_last) begin
            r_rep <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            // a pop happens only when idle or on the last byte of an entry
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv) begin
                if (at_end) begin
                    r_idx <= '0;
                    if (entry_last) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/utf16_to_utf8_transcoder_unit.sv
// top level of the utf-16/utf-32 to utf-8 transcoder
//
// takes one wide code unit per input beat and emits its utf-8 bytes, one byte per
// output beat, with tlast on the final byte caused by that unit. with the mode
// register at 0 the unit is utf-16: a high surrogate is held (no output) until the
// next unit; a following low surrogate yields one four-byte sequence, anything else
// yields u+fffd and is then handled afresh. a lone low surrogate yields u+fffd, and
// a high surrogate marked end of string is encoded as itself. with the mode register
// at 1 every 21-bit value is encoded by length class. writing the register drops
// any held surrogate; write it only while the block is idle. a unit yields up to six
// output bytes (none for a held high surrogate); the byte engine emits one byte per
// cycle while the output side accepts. the front end classifies a unit in the cycle it
// is accepted and keeps taking units while the queue has room, so a stalled output
// side does not stall the input until the queue fills
module utf16_to_utf8_transcoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: wide_is_32bit
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [20:0] code_unit, [23:21] zero
    input  logic        i_s_axis_tlast,   // end_of_string
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast    // last_of_run
);
    import u2u8_pkg::*;

    // front to queue
    logic   push;
    t_entry push_entry;
    logic   q_full;

    // queue to back
    logic   q_valid;
    t_entry q_entry;
    logic   pop;

    // classify and pair surrogates
    u2u8_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_s_axis_tvalid),
        .i_code_unit     (i_s_axis_tdata[20:0]),
        .i_end_of_string (i_s_axis_tlast),
        .i_q_full        (q_full),
        .o_in_ready      (o_s_axis_tready),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    // decouples unit acceptance from byte emission
    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // serialize bytes into the output register
    u2u8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (q_entry),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

FILE: tb/utf16_to_utf8_transcoder_unit_test.sv
// self-checking testbench for the utf-16/utf-32 to utf-8 transcoder
module utf16_to_utf8_transcoder_unit_test;

    import u2u8_pkg::*;

    // mode register values
    typedef enum logic {
        MODE_UTF16 = 1'b0,
        MODE_UTF32 = 1'b1
    } t_wide_mode;

    // one expected output beat: the byte and its end-of-run mark
    typedef struct packed {
        logic [7:0] octet;
        logic       tail;
    } t_utf8_beat;

    // one directed stimulus row; typed bytes sit first byte highest
    typedef struct packed {
        t_wide_mode      mode;
        logic [CP_W-1:0] unit;
        logic            eos;
        int              n_typed;
        logic [47:0]     typed;
    } t_probe_row;

    localparam int NO_TYPED       = -1;
    localparam int SETTLE_CYCLES  = 12;      // front end plus byte engine, with margin
    localparam int SQUEEZE_CYCLES = 80;      // long receiver hold-off
    localparam int CYCLE_LIMIT    = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;        // [20:0] code_unit, [23:21] zero
    logic        i_s_axis_tlast = 1'b0;      // end_of_string
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;             // [7:0] out_byte
    logic        o_m_axis_tlast;             // last_of_run

    // predictor state, updated at the edges where the block sees the same events
    t_wide_mode  pred_mode = MODE_UTF16;
    logic        pred_held = 1'b0;
    logic [9:0]  pred_held_bits = '0;
    t_utf8_beat  expected_octets [$];

    // directed rows may carry hand-written bytes that replace the prediction
    int          typed_count = NO_TYPED;
    logic [47:0] typed_octets = '0;

    // pacing controls shared between the stimulus thread and the receiver
    logic        src_steady = 1'b0;
    logic        sink_steady = 1'b0;
    logic        squeeze_req = 1'b0;
    int          sink_wait = 0;

    t_wide_mode  cur_mode = MODE_UTF16;
    int          units_sent = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    t_probe_row  probe_rows [$];

    utf16_to_utf8_transcoder_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes still expected", $time,
                     expected_octets.size());
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 24);
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    task automatic push_octet(input logic [7:0] b);
        expected_octets.push_back({b, 1'b0});
    endtask

    // utf-8 bytes of one code point, chosen by length class
    task automatic push_code_point(input logic [CP_W-1:0] cp);
        if (cp <= CP_MAX_1B) begin
            push_octet({1'b0, cp[6:0]});
        end else if (cp <= CP_MAX_2B) begin
            push_octet({3'b110, cp[10:6]});
            push_octet({2'b10, cp[5:0]});
        end else if (cp <= CP_MAX_3B) begin
            push_octet({4'b1110, cp[15:12]});
            push_octet({2'b10, cp[11:6]});
            push_octet({2'b10, cp[5:0]});
        end else begin
            push_octet({5'b11110, cp[20:18]});
            push_octet({2'b10, cp[17:12]});
            push_octet({2'b10, cp[11:6]});
            push_octet({2'b10, cp[5:0]});
        end
    endtask

    // expected bytes of one accepted input beat, appended to the queue
    task automatic predict_unit(input logic [CP_W-1:0] unit, input logic eos);
        logic [15:0]     u16;
        logic            is_high;
        logic            is_low;
        logic [CP_W-1:0] cp;
        int              base;
        t_utf8_beat      closing;
        base = expected_octets.size();
        u16 = unit[15:0];
        is_high = (u16 >= HIGH_FIRST) && (u16 <= HIGH_LAST);
        is_low = (u16 >= LOW_FIRST) && (u16 <= LOW_LAST);
        if (pred_mode == MODE_UTF32) begin
            // utf-32 encodes every value directly, nothing is ever held
            pred_held = 1'b0;
            pred_held_bits = '0;
            push_code_point(unit);
        end else if (pred_held && is_low) begin
            // surrogate pair: one supplementary code point
            cp = CP_SUPP_BASE + {1'b0, pred_held_bits, 10'b0} + CP_W'(u16 - LOW_FIRST);
            pred_held = 1'b0;
            pred_held_bits = '0;
            push_code_point(cp);
        end else begin
            // a held high not followed by a low turns into u+fffd first
            if (pred_held) begin
                pred_held = 1'b0;
                pred_held_bits = '0;
                push_code_point(CP_REPLACEMENT);
            end
            if (is_high) begin
                if (eos) begin
                    // high surrogate at end of string goes out as itself
                    push_code_point({5'b0, u16});
                end else begin
                    pred_held = 1'b1;
                    pred_held_bits = u16[9:0];
                end
            end else if (is_low) begin
                push_code_point(CP_REPLACEMENT);
            end else begin
                push_code_point({5'b0, u16});
            end
        end
        // hand-written bytes of a directed row stand in for the predicted ones
        if (typed_count != NO_TYPED) begin
            while (expected_octets.size() > base) begin
                void'(expected_octets.pop_back());
            end
            for (int k = 0; k < typed_count; k++) begin
                push_octet(typed_octets[47 - 8 * k -: 8]);
            end
        end
        if (expected_octets.size() > base) begin
            closing = expected_octets[expected_octets.size() - 1];
            closing.tail = 1'b1;
            expected_octets[expected_octets.size() - 1] = closing;
        end
    endtask

    // ------------------------------------------------------------------
    // monitor and scoreboard, all on the rising edge
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_utf8_beat got;
        t_utf8_beat want;
        if (i_rst_n) begin
            // a mode write drops any held high surrogate
            if (i_cfg_we) begin
                pred_mode = t_wide_mode'(i_cfg_wdata);
                pred_held = 1'b0;
                pred_held_bits = '0;
            end
            // predict first so a beat accepted now is queued before any check
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_unit(i_s_axis_tdata[CP_W-1:0], i_s_axis_tlast);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tdata, o_m_axis_tlast};
                if (expected_octets.size() == 0) begin
                    $display("%0t: unexpected output beat byte=%02h last=%0b", $time,
                             got.octet, got.tail);
                    error_count = error_count + 1;
                end else begin
                    want = expected_octets.pop_front();
                    if (got.octet !== want.octet) begin
                        $display("%0t: out_byte mismatch expected %02h actual %02h", $time,
                                 want.octet, got.octet);
                        error_count = error_count + 1;
                    end
                    if (got.tail !== want.tail) begin
                        $display("%0t: last_of_run mismatch expected %0b actual %0b", $time,
                                 want.tail, got.tail);
                        error_count = error_count + 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, steady stretches, and one long hold-off
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (squeeze_req) begin
            squeeze_req = 1'b0;
            sink_wait = SQUEEZE_CYCLES;
        end
        if (sink_wait > 0) begin
            sink_wait = sink_wait - 1;
            i_m_axis_tready <= 1'b0;
        end else if (sink_steady || $urandom_range(0, 99) < 65) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= 1'b0;
            sink_wait = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offer one beat and hold it until accepted; valid stays high into
    // the next call when no gap follows, so it is never dropped and raised
    // in the same step
    task automatic send_unit(input logic [CP_W-1:0] unit, input logic eos,
                             input int n_typed, input logic [47:0] typed);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        typed_count = n_typed;
        typed_octets = typed;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, unit};
        i_s_axis_tlast <= eos;
        do @(posedge i_clk); while (!o_s_axis_tready);
        units_sent = units_sent + 1;
    endtask

    task automatic send_free(input logic [CP_W-1:0] unit, input logic eos);
        send_unit(unit, eos, NO_TYPED, '0);
    endtask

    // stop offering, let every expected byte arrive, then let a held
    // surrogate or an in-flight beat settle
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_octets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // mode writes only while the block is idle
    task automatic set_mode(input t_wide_mode mode);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic add_row(input t_wide_mode mode, input logic [CP_W-1:0] unit,
                           input logic eos, input int n_typed, input logic [47:0] typed);
        probe_rows.push_back({mode, unit, eos, n_typed, typed});
    endtask

    // one utf-16 character: mostly well-formed text, some broken surrogates
    task automatic send_text_char(input logic closes);
        int          pick;
        logic [15:0] u;
        logic [15:0] hi;
        logic [15:0] lo;
        pick = $urandom_range(0, 99);
        hi = HIGH_FIRST + 16'($urandom_range(0, 16'h3FF));
        lo = LOW_FIRST + 16'($urandom_range(0, 16'h3FF));
        // bits above 15 are ignored in utf-16 mode, so fill them with junk
        if (pick < 22) begin
            u = 16'($urandom_range(0, 16'h7F));
            send_free({5'($urandom), u}, closes);
        end else if (pick < 38) begin
            u = 16'($urandom_range(16'h80, 16'h7FF));
            send_free({5'($urandom), u}, closes);
        end else if (pick < 58) begin
            // bmp outside the surrogate block
            u = 16'($urandom_range(16'h800, 16'hF7FF));
            if (u >= HIGH_FIRST) begin
                u = u + 16'h800;
            end
            send_free({5'($urandom), u}, closes);
        end else if (pick < 84) begin
            send_free({5'($urandom), hi}, 1'b0);
            send_free({5'($urandom), lo}, closes);
        end else if (pick < 90) begin
            // lone low surrogate
            send_free({5'($urandom), lo}, closes);
        end else if (pick < 95) begin
            // high surrogate followed by a non-low unit
            send_free({5'($urandom), hi}, 1'b0);
            send_free({5'($urandom), 16'($urandom_range(0, 16'hD7FF))}, closes);
        end else begin
            // high surrogate closing the string
            send_free({5'($urandom), hi}, 1'b1);
        end
    endtask

    // utf-32 value spread over the four length classes, beyond 0x10FFFF too
    function automatic logic [CP_W-1:0] pick_wide_value();
        case ($urandom_range(0, 3))
            0:       return CP_W'($urandom_range(0, 21'h7F));
            1:       return CP_W'($urandom_range(21'h80, 21'h7FF));
            2:       return CP_W'($urandom_range(21'h800, 21'hFFFF));
            default: return CP_W'($urandom_range(21'h10000, 21'h1FFFFF));
        endcase
    endfunction

    task automatic run_phase(input t_wide_mode mode, input int count,
                             input logic steady_src, input logic steady_sink,
                             input logic squeeze);
        int stop;
        int len;
        set_mode(mode);
        @(posedge i_clk);
        src_steady = steady_src;
        sink_steady = steady_sink;
        squeeze_req = squeeze;
        stop = units_sent + count;
        while (units_sent < stop) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                if (mode == MODE_UTF32) begin
                    send_free(pick_wide_value(), $urandom_range(0, 4) == 0);
                end else begin
                    send_text_char(k == len - 1);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        // utf-16 rows straight after reset, mode register untouched
        add_row(MODE_UTF16, 21'h000000, 1'b0, 1, 48'h00_0000000000);
        add_row(MODE_UTF16, 21'h00007F, 1'b0, 1, 48'h7F_0000000000);
        add_row(MODE_UTF16, 21'h000080, 1'b0, 2, 48'hC280_00000000);
        add_row(MODE_UTF16, 21'h0007FF, 1'b0, 2, 48'hDFBF_00000000);
        add_row(MODE_UTF16, 21'h000800, 1'b0, 3, 48'hE0A080_000000);
        add_row(MODE_UTF16, 21'h00FFFF, 1'b0, 3, 48'hEFBFBF_000000);
        // bits above 15 ignored: same as 0xFFFF
        add_row(MODE_UTF16, 21'h1FFFFF, 1'b0, 3, 48'hEFBFBF_000000);
        // lowest pair gives u+10000, highest pair gives u+10ffff
        add_row(MODE_UTF16, 21'h00D800, 1'b0, 0, 48'h0);
        add_row(MODE_UTF16, 21'h00DC00, 1'b0, 4, 48'hF0908080_0000);
        add_row(MODE_UTF16, 21'h00DBFF, 1'b0, 0, 48'h0);
        add_row(MODE_UTF16, 21'h00DFFF, 1'b0, 4, 48'hF48FBFBF_0000);
        // lone low surrogate
        add_row(MODE_UTF16, 21'h00DC00, 1'b0, 3, 48'hEFBFBD_000000);
        // held high then a plain unit at end of string
        add_row(MODE_UTF16, 21'h00D834, 1'b0, NO_TYPED, 48'h0);
        add_row(MODE_UTF16, 21'h000041, 1'b1, 4, 48'hEFBFBD41_0000);
        // high surrogate closing the string encodes as itself
        add_row(MODE_UTF16, 21'h00DBFF, 1'b1, 3, 48'hEDAFBF_000000);
        // held high replaced by another high, then a high at end: six bytes
        add_row(MODE_UTF16, 21'h00D800, 1'b0, 0, 48'h0);
        add_row(MODE_UTF16, 21'h00D801, 1'b0, 3, 48'hEFBFBD_000000);
        add_row(MODE_UTF16, 21'h00D802, 1'b1, 6, 48'hEFBFBDEDA082);
        add_row(MODE_UTF16, 21'h0020AC, 1'b0, NO_TYPED, 48'h0);
        // held high left pending: the mode write must drop it
        add_row(MODE_UTF16, 21'h00D800, 1'b0, 0, 48'h0);
        // utf-32: surrogate values and values past 0x10ffff encode directly
        add_row(MODE_UTF32, 21'h00FFFF, 1'b0, 3, 48'hEFBFBF_000000);
        add_row(MODE_UTF32, 21'h010000, 1'b0, NO_TYPED, 48'h0);
        add_row(MODE_UTF32, 21'h00D800, 1'b0, 3, 48'hEDA080_000000);
        add_row(MODE_UTF32, 21'h110000, 1'b0, 4, 48'hF4908080_0000);
        add_row(MODE_UTF32, 21'h1FFFFF, 1'b1, 4, 48'hF7BFBFBF_0000);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probe_rows[i]) begin
            if (probe_rows[i].mode != cur_mode) begin
                set_mode(probe_rows[i].mode);
            end
            send_unit(probe_rows[i].unit, probe_rows[i].eos, probe_rows[i].n_typed,
                      probe_rows[i].typed);
        end

        // random phases across both modes; the third one holds the receiver
        // off while the sender streams without gaps, so the queue fills
        run_phase(MODE_UTF16, 40, 1'b0, 1'b0, 1'b0);
        run_phase(MODE_UTF32, 25, 1'b1, 1'b1, 1'b0);
        run_phase(MODE_UTF16, 25, 1'b1, 1'b0, 1'b1);
        run_phase(MODE_UTF32, 15, 1'b0, 1'b0, 1'b0);
        run_phase(MODE_UTF16, 25, 1'b0, 1'b0, 1'b0);

        drain();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
